>>> hdl/cfl_time_step_reduction_unit_assert.svh
// Assertion macros for the time-step reduction unit.
// Each macro takes a label, the clock, the active-low reset, a condition and a consequence.
`ifndef CFL_TIME_STEP_REDUCTION_UNIT_ASSERT_SVH
`define CFL_TIME_STEP_REDUCTION_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CFLTS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication.
`define CFLTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

>>> hdl/cflts_pkg.sv
`default_nettype none

package cflts_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int CFG_IDX_W     = 1;

    localparam logic [DATA_W-1:0] CFL_RESET = 32'h0000_8000;
    localparam logic [DATA_W-1:0] END_RESET = 32'h0000_0000;
    localparam logic [DATA_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CFL_NUMBER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_U,
        S_DIV_V,
        S_DIV_FB,
        S_DIV_DT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

>>> hdl/cflts_divider.sv
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
module cflts_divider #(
    parameter int W = 49
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cflts_pkg::div_ctrl_t ctrl,
    input  wire logic [W-1:0]        num,
    input  wire logic [W-1:0]        den,
    output cflts_pkg::div_stat_t     stat,
    output logic [W-1:0]             quo
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     q_reg, q_next;
    logic [W-1:0]     den_reg, den_next;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    always_comb
    begin
        trial = {rem_reg, q_reg[W-1]};
        diff  = trial - {1'b0, den_reg};
        // no borrow out of the top bit means the divisor fits
        ge    = !diff[W];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        if (ctrl.start)
        begin
            // load operands, clear the partial remainder
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            rem_next  = '0;
            q_next    = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[W-1:0] : trial[W-1:0];
            q_next   = {q_reg[W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = q_reg;

endmodule

`default_nettype wire

>>> hdl/cfl_time_step_reduction_unit.sv
// CFL time-step reduction unit.
// Input channel (in_valid / in_stall) carries one grid cell per transfer: four face
// velocities, cell size, fluid flag, present time and a last-cell mark. Output channel
// (out_valid / out_stall) carries one result per sweep, on the last cell: the allowed
// time step, a no-fluid flag and an end-clamp flag.
// A solid cell that is not last needs no division. A fluid cell runs three divisions
// (four when its convection is zero and the fallback is nonzero) on one shared
// restoring divider of W = FRAC_BITS + 33 bits (49 at Q16.16). The divider is the
// limiting unit; in_stall stays high meanwhile. The last cell also forms the clamped
// step into the output register.
// A waiting result does not block the next cells; only the next last cell waits while
// the output register is still full and out_stall is high.
// Reset: cfl_number returns to 0.5, end_time to 0 (clamp off), the running minimum
// to all ones, and the output register empties.
// Configuration is written through cfg_we / cfg_index / cfg_data while the block
// is idle; the user must keep to this, the block itself does not enforce it.
`default_nettype none

module cfl_time_step_reduction_unit #(
    parameter int FRAC_BITS = cflts_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration
    input  wire logic                             cfg_we,
    input  wire logic [cflts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cflts_pkg::DATA_W-1:0]     cfg_data,
    // cell input
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic signed [31:0]               u_left,
    input  wire logic signed [31:0]               u_right,
    input  wire logic signed [31:0]               v_bottom,
    input  wire logic signed [31:0]               v_top,
    input  wire logic [31:0]                      cell_width,
    input  wire logic [31:0]                      cell_height,
    input  wire logic                             is_fluid,
    input  wire logic [31:0]                      current_time,
    input  wire logic                             last_cell,
    // result output
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [31:0]                           time_step,
    output logic                                  no_fluid,
    output logic                                  end_clamped
);

    `include "cfl_time_step_reduction_unit_assert.svh"

    // divider width covers (|sum| << F), (cfl << F), 2^(2F) and the convection sum
    localparam int W = FRAC_BITS + 33;

    cflts_pkg::state_t state_reg, state_next;

    // configuration
    logic [31:0] cfl_reg, cfl_next;
    logic [31:0] end_reg, end_next;

    // latched cell
    logic [32:0] u_abs_reg, u_abs_next;
    logic [32:0] v_abs_reg, v_abs_next;
    logic [31:0] dx_reg, dx_next;
    logic [31:0] dy_reg, dy_next;
    logic [31:0] tcur_reg, tcur_next;
    logic        last_reg, last_next;

    // sweep state
    logic [W-1:0] conv_reg, conv_next;
    logic [31:0]  min_reg, min_next;
    logic         seen_reg, seen_next;
    logic         start_reg, start_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] ts_reg, ts_next;
    logic        nf_reg, nf_next;
    logic        ec_reg, ec_next;

    // divider link
    cflts_pkg::div_ctrl_t div_ctrl;
    cflts_pkg::div_stat_t div_stat;
    logic [W-1:0]         div_num;
    logic [W-1:0]         div_den;
    logic [W-1:0]         div_quo;

    // combinational helpers
    logic        accept;
    logic        emit_fire;
    logic signed [32:0] u_sum;
    logic signed [32:0] v_sum;
    logic [W-1:0] conv_sum;
    logic [31:0]  min_dxy;
    logic [31:0]  cell_step;
    logic         upd_en;
    logic [32:0]  t_reach;
    logic         clamp;

    assign accept    = in_valid && !in_stall;
    assign emit_fire = (state_reg == cflts_pkg::S_EMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        u_sum    = {u_left[31], u_left} + {u_right[31], u_right};
        v_sum    = {v_bottom[31], v_bottom} + {v_top[31], v_top};
        conv_sum = conv_reg + div_quo;
        min_dxy  = (dx_reg < dy_reg) ? dx_reg : dy_reg;
        // saturate the local step to 32 bits; a zero fallback quotient saturates too
        if (state_reg == cflts_pkg::S_DIV_FB)
            cell_step = cflts_pkg::ALL_ONES;
        else if (|div_quo[W-1:32])
            cell_step = cflts_pkg::ALL_ONES;
        else
            cell_step = div_quo[31:0];
        upd_en = div_stat.done &&
                 ((state_reg == cflts_pkg::S_DIV_DT) ||
                  ((state_reg == cflts_pkg::S_DIV_FB) && (div_quo == '0)));
        t_reach = {1'b0, tcur_reg} + {1'b0, min_reg};
        clamp   = (min_reg != '0) && (end_reg != '0) && (t_reach > {1'b0, end_reg});
    end

    // pick the operands of the division for the current phase
    always_comb
    begin
        div_num = '0;
        div_den = W'(1);
        case (state_reg)
            cflts_pkg::S_DIV_U:
            begin
                div_num = {u_abs_reg, FRAC_BITS'(0)};
                div_den = W'({dx_reg, 1'b0});
            end
            cflts_pkg::S_DIV_V:
            begin
                div_num = {v_abs_reg, FRAC_BITS'(0)};
                div_den = W'({dy_reg, 1'b0});
            end
            cflts_pkg::S_DIV_FB:
            begin
                div_num = W'(1) << (2 * FRAC_BITS);
                div_den = W'(min_dxy);
            end
            cflts_pkg::S_DIV_DT:
            begin
                div_num = {1'b0, cfl_reg, FRAC_BITS'(0)};
                div_den = conv_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = W'(1);
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cflts_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (is_fluid)
                        state_next = cflts_pkg::S_DIV_U;
                    else if (last_cell)
                        state_next = cflts_pkg::S_EMIT;
                end
            end
            cflts_pkg::S_DIV_U:
            begin
                if (div_stat.done)
                    state_next = cflts_pkg::S_DIV_V;
            end
            cflts_pkg::S_DIV_V:
            begin
                if (div_stat.done)
                    state_next = (conv_sum == '0) ? cflts_pkg::S_DIV_FB : cflts_pkg::S_DIV_DT;
            end
            cflts_pkg::S_DIV_FB:
            begin
                if (div_stat.done)
                begin
                    if (div_quo != '0)
                        state_next = cflts_pkg::S_DIV_DT;
                    else
                        state_next = last_reg ? cflts_pkg::S_EMIT : cflts_pkg::S_IDLE;
                end
            end
            cflts_pkg::S_DIV_DT:
            begin
                if (div_stat.done)
                    state_next = last_reg ? cflts_pkg::S_EMIT : cflts_pkg::S_IDLE;
            end
            cflts_pkg::S_EMIT:
            begin
                if (emit_fire)
                    state_next = cflts_pkg::S_IDLE;
            end
            default:
            begin
                state_next = cflts_pkg::S_IDLE;
            end
        endcase
    end

    // FSM outputs: launch the divider on entry to each division phase
    always_comb
    begin
        in_stall   = (state_reg != cflts_pkg::S_IDLE);
        start_next = (state_next != state_reg) &&
                     ((state_next == cflts_pkg::S_DIV_U)  ||
                      (state_next == cflts_pkg::S_DIV_V)  ||
                      (state_next == cflts_pkg::S_DIV_FB) ||
                      (state_next == cflts_pkg::S_DIV_DT));
        div_ctrl.start = start_reg;
    end

    // datapath
    always_comb
    begin
        cfl_next       = cfl_reg;
        end_next       = end_reg;
        u_abs_next     = u_abs_reg;
        v_abs_next     = v_abs_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        tcur_next      = tcur_reg;
        last_next      = last_reg;
        conv_next      = conv_reg;
        min_next       = min_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && out_stall;
        ts_next        = ts_reg;
        nf_next        = nf_reg;
        ec_next        = ec_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                cflts_pkg::CFG_CFL_NUMBER: cfl_next = cfg_data;
                cflts_pkg::CFG_END_TIME:   end_next = cfg_data;
                default:                   cfl_next = cfl_reg;
            endcase
        end

        if (accept)
        begin
            // take absolute face sums and floor the cell size to one LSB
            u_abs_next = u_sum[32] ? (~u_sum + 33'd1) : u_sum;
            v_abs_next = v_sum[32] ? (~v_sum + 33'd1) : v_sum;
            dx_next    = (cell_width == '0) ? 32'd1 : cell_width;
            dy_next    = (cell_height == '0) ? 32'd1 : cell_height;
            tcur_next  = current_time;
            last_next  = last_cell;
            seen_next  = seen_reg || is_fluid;
        end

        if (div_stat.done)
        begin
            case (state_reg)
                cflts_pkg::S_DIV_U:  conv_next = div_quo;
                cflts_pkg::S_DIV_V:  conv_next = conv_sum;
                cflts_pkg::S_DIV_FB: conv_next = div_quo;
                default:             conv_next = conv_reg;
            endcase
        end

        if (upd_en && (cell_step < min_reg))
            min_next = cell_step;

        if (emit_fire)
        begin
            // clamp so the step does not pass end_time, then restart the sweep
            out_valid_next = 1'b1;
            nf_next        = !seen_reg;
            ec_next        = clamp;
            if (clamp)
                ts_next = (tcur_reg >= end_reg) ? 32'd0 : (end_reg - tcur_reg);
            else
                ts_next = min_reg;
            min_next  = cflts_pkg::ALL_ONES;
            seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cflts_pkg::S_IDLE;
            start_reg     <= 1'b0;
            cfl_reg       <= cflts_pkg::CFL_RESET;
            end_reg       <= cflts_pkg::END_RESET;
            min_reg       <= cflts_pkg::ALL_ONES;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            cfl_reg       <= cfl_next;
            end_reg       <= end_next;
            min_reg       <= min_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_abs_reg <= u_abs_next;
        v_abs_reg <= v_abs_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        tcur_reg  <= tcur_next;
        last_reg  <= last_next;
        conv_reg  <= conv_next;
        ts_reg    <= ts_next;
        nf_reg    <= nf_next;
        ec_reg    <= ec_next;
    end

    cflts_divider #(
        .W (W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    assign out_valid   = out_valid_reg;
    assign time_step   = ts_reg;
    assign no_fluid    = nf_reg;
    assign end_clamped = ec_reg;

    // The divider is never relaunched while it is still iterating.
    `CFLTS_ASSERT_NOW(a_no_restart_busy, clk, rst_n, div_ctrl.start, !div_stat.busy)
    // A finished division is only seen in a division phase.
    `CFLTS_ASSERT_NOW(a_done_in_phase, clk, rst_n, div_stat.done,
        (state_reg == cflts_pkg::S_DIV_U) || (state_reg == cflts_pkg::S_DIV_V) ||
        (state_reg == cflts_pkg::S_DIV_FB) || (state_reg == cflts_pkg::S_DIV_DT))
    // A fluid cell always occupies the block for its divisions.
    `CFLTS_ASSERT_NEXT(a_fluid_busy, clk, rst_n, accept && is_fluid, in_stall)
    // A sweep without fluid and without clamp reports the saturated step.
    `CFLTS_ASSERT_NOW(a_no_fluid_max, clk, rst_n, out_valid && no_fluid && !end_clamped,
        time_step == cflts_pkg::ALL_ONES)

endmodule

`default_nettype wire
